/* hw/rtl/incremental_pi_controller_assert.svh */
// assertion macros for the incremental pi controller
`ifndef INCREMENTAL_PI_CONTROLLER_ASSERT_SVH
`define INCREMENTAL_PI_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define IPI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");
// condition implies consequence in the next cycle
`define IPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");
`else
`define IPI_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IPI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/ipi_pkg.sv */
package ipi_pkg;

	// fixed field widths
	localparam int DATA_W  = 16;
	localparam int GAIN_W  = 16;
	localparam int LIMIT_W = 13;
	localparam int ERR_W   = DATA_W + 1;

	// gain fraction bits and the default accumulator fraction bits
	localparam int GAIN_FRAC     = 8;
	localparam int FRAC_BITS_DEF = 12;

	// apb side
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OUT_FLOOR   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OUT_CEILING = 3'd4;

	// reset values
	localparam logic signed [DATA_W-1:0] SETPOINT_RST    = 16'sd2048;
	localparam logic [GAIN_W-1:0]        PROP_GAIN_RST   = 16'd1280;
	localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST  = 16'd102;
	localparam logic [LIMIT_W-1:0]       OUT_FLOOR_RST   = 13'd20;
	localparam logic [LIMIT_W-1:0]       OUT_CEILING_RST = 13'd5200;

	// configuration handed to the datapath
	typedef struct packed {
		logic signed [DATA_W-1:0] setpoint;
		logic [GAIN_W-1:0]        prop_gain;
		logic [GAIN_W-1:0]        integ_gain;
		logic [LIMIT_W-1:0]       out_floor;
		logic [LIMIT_W-1:0]       out_ceiling;
	} ipi_cfg_t;

endpackage

/* hw/rtl/ipi_regs.sv */
module ipi_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ipi_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [ipi_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ipi_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	output ipi_pkg::ipi_cfg_t                   cfg
);

	logic                                  wr_en;
	logic [ipi_pkg::REG_IDX_W-1:0]         idx;
	ipi_pkg::ipi_cfg_t                     cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ipi_pkg::APB_ADDR_W-1:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint    <= ipi_pkg::SETPOINT_RST;
			cfg_q.prop_gain   <= ipi_pkg::PROP_GAIN_RST;
			cfg_q.integ_gain  <= ipi_pkg::INTEG_GAIN_RST;
			cfg_q.out_floor   <= ipi_pkg::OUT_FLOOR_RST;
			cfg_q.out_ceiling <= ipi_pkg::OUT_CEILING_RST;
		end else if (wr_en) begin
			case (idx)
				ipi_pkg::REG_SETPOINT: begin
					cfg_q.setpoint <= $signed(pwdata[ipi_pkg::DATA_W-1:0]);
				end
				ipi_pkg::REG_PROP_GAIN: begin
					cfg_q.prop_gain <= pwdata[ipi_pkg::GAIN_W-1:0];
				end
				ipi_pkg::REG_INTEG_GAIN: begin
					cfg_q.integ_gain <= pwdata[ipi_pkg::GAIN_W-1:0];
				end
				ipi_pkg::REG_OUT_FLOOR: begin
					cfg_q.out_floor <= pwdata[ipi_pkg::LIMIT_W-1:0];
				end
				ipi_pkg::REG_OUT_CEILING: begin
					cfg_q.out_ceiling <= pwdata[ipi_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// readback, setpoint sign extended
	always_comb begin
		case (idx)
			ipi_pkg::REG_SETPOINT: begin
				prdata = {{(ipi_pkg::APB_DATA_W-ipi_pkg::DATA_W){cfg_q.setpoint[ipi_pkg::DATA_W-1]}},
					cfg_q.setpoint};
			end
			ipi_pkg::REG_PROP_GAIN: begin
				prdata = {{(ipi_pkg::APB_DATA_W-ipi_pkg::GAIN_W){1'b0}}, cfg_q.prop_gain};
			end
			ipi_pkg::REG_INTEG_GAIN: begin
				prdata = {{(ipi_pkg::APB_DATA_W-ipi_pkg::GAIN_W){1'b0}}, cfg_q.integ_gain};
			end
			ipi_pkg::REG_OUT_FLOOR: begin
				prdata = {{(ipi_pkg::APB_DATA_W-ipi_pkg::LIMIT_W){1'b0}}, cfg_q.out_floor};
			end
			ipi_pkg::REG_OUT_CEILING: begin
				prdata = {{(ipi_pkg::APB_DATA_W-ipi_pkg::LIMIT_W){1'b0}}, cfg_q.out_ceiling};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

/* hw/rtl/ipi_step.sv */
module ipi_step #(
	parameter int FRAC_BITS = ipi_pkg::FRAC_BITS_DEF
) (
	input  logic signed [ipi_pkg::DATA_W-1:0]   meas,
	input  ipi_pkg::ipi_cfg_t                   cfg,
	input  logic [ipi_pkg::LIMIT_W+FRAC_BITS-1:0] acc,
	input  logic signed [ipi_pkg::ERR_W-1:0]    prev_err,
	output logic [ipi_pkg::LIMIT_W+FRAC_BITS-1:0] acc_next,
	output logic signed [ipi_pkg::ERR_W-1:0]    err,
	output logic                                clamped
);

	localparam int ACC_W   = ipi_pkg::LIMIT_W + FRAC_BITS;
	localparam int ERR_W   = ipi_pkg::ERR_W;
	localparam int DIFF_W  = ERR_W + 1;
	localparam int PPROD_W = ipi_pkg::GAIN_W + 1 + DIFF_W;
	localparam int IPROD_W = ipi_pkg::GAIN_W + 1 + ERR_W;
	localparam int PSUM_W  = PPROD_W + 1;
	localparam int INC_W   = PSUM_W - ipi_pkg::GAIN_FRAC;
	localparam int SUM_W   = ((ACC_W > INC_W) ? ACC_W : INC_W) + 2;

	logic signed [DIFF_W-1:0]           diff;
	logic signed [ipi_pkg::GAIN_W:0]    kp_s;
	logic signed [ipi_pkg::GAIN_W:0]    ki_s;
	logic signed [PPROD_W-1:0]          pprod;
	logic signed [IPROD_W-1:0]          iprod;
	logic signed [PSUM_W-1:0]           psum;
	logic signed [PSUM_W-1:0]           prnd;
	logic signed [INC_W-1:0]            inc;
	logic signed [SUM_W-1:0]            acc_sum;
	logic signed [SUM_W-1:0]            hi;
	logic signed [SUM_W-1:0]            lo;
	logic signed [SUM_W-1:0]            acc_clip;

	// error and its change against the last sample
	assign err  = $signed({meas[ipi_pkg::DATA_W-1], meas})
		- $signed({cfg.setpoint[ipi_pkg::DATA_W-1], cfg.setpoint});
	assign diff = $signed({err[ERR_W-1], err}) - $signed({prev_err[ERR_W-1], prev_err});

	// gain products, both exact
	assign kp_s  = $signed({1'b0, cfg.prop_gain});
	assign ki_s  = $signed({1'b0, cfg.integ_gain});
	assign pprod = kp_s * diff;
	assign iprod = ki_s * err;

	// sum and round half up to the accumulator fraction
	assign psum = $signed({pprod[PPROD_W-1], pprod})
		+ $signed({{(PSUM_W-IPROD_W){iprod[IPROD_W-1]}}, iprod});
	assign prnd = psum + $signed({{(PSUM_W-ipi_pkg::GAIN_FRAC){1'b0}},
		1'b1, {(ipi_pkg::GAIN_FRAC-1){1'b0}}});
	assign inc  = prnd[PSUM_W-1:ipi_pkg::GAIN_FRAC];

	// accumulate
	assign acc_sum = $signed({{(SUM_W-ACC_W){1'b0}}, acc})
		+ $signed({{(SUM_W-INC_W){inc[INC_W-1]}}, inc});

	// limits in accumulator scale
	assign hi = $signed({{(SUM_W-ACC_W){1'b0}}, cfg.out_ceiling, {FRAC_BITS{1'b0}}});
	assign lo = $signed({{(SUM_W-ACC_W){1'b0}}, cfg.out_floor, {FRAC_BITS{1'b0}}});

	// clamp, ceiling first, floor wins
	always_comb begin
		acc_clip = acc_sum;
		clamped  = 1'b0;
		if (acc_clip > hi) begin
			acc_clip = hi;
			clamped  = 1'b1;
		end
		if (acc_clip < lo) begin
			acc_clip = lo;
			clamped  = 1'b1;
		end
	end

	assign acc_next = acc_clip[ACC_W-1:0];

endmodule

/* hw/rtl/incremental_pi_controller.sv */
// Incremental PI controller: each beat on the input channel is one signed Q4.12 sample;
// each result beat carries the clamped drive value (PWM compare) and an at-limit flag.
// One sample per clock is sustained while the result side keeps taking results. A sample
// is registered in the sample stage when accepted; its result is written to the output
// register when the sample stage advances, which waits while an untaken result holds
// the slot. The rate is set by the update of the output accumulator and the previous
// error, which the whole error, gain multiply, round and clamp path feeds.
// Registers sit on an APB port at byte offsets 0x00 setpoint, 0x04 prop_gain,
// 0x08 integ_gain, 0x0C out_floor, 0x10 out_ceiling; write them only while idle.
module incremental_pi_controller #(
	parameter int FRAC_BITS = ipi_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ipi_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [ipi_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ipi_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [ipi_pkg::DATA_W-1:0]   measured_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ipi_pkg::LIMIT_W-1:0]         drive_value,
	output logic                                at_limit
);

	localparam int ACC_W = ipi_pkg::LIMIT_W + FRAC_BITS;

	ipi_pkg::ipi_cfg_t                   cfg;
	logic                                valid_s1;
	logic signed [ipi_pkg::DATA_W-1:0]   meas_s1;
	logic                                advance;
	logic [ACC_W-1:0]                    acc_q;
	logic signed [ipi_pkg::ERR_W-1:0]    prev_err_q;
	logic [ACC_W-1:0]                    acc_next;
	logic signed [ipi_pkg::ERR_W-1:0]    err;
	logic                                clamped;
	logic                                out_valid_q;
	logic [ipi_pkg::LIMIT_W-1:0]         drive_q;
	logic                                at_limit_q;

	ipi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ipi_step #(
		.FRAC_BITS (FRAC_BITS)
	) u_step (
		.meas     (meas_s1),
		.cfg      (cfg),
		.acc      (acc_q),
		.prev_err (prev_err_q),
		.acc_next (acc_next),
		.err      (err),
		.clamped  (clamped)
	);

	// handshake: the sample stage moves on when the result slot is free or drains
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	// sample stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			meas_s1 <= measured_value;
		end
	end

	// controller state, updated once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			prev_err_q <= '0;
		end else if (advance) begin
			acc_q      <= acc_next;
			prev_err_q <= err;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q    <= acc_next[ACC_W-1:FRAC_BITS];
			at_limit_q <= clamped;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;
	assign at_limit    = at_limit_q;

`include "incremental_pi_controller_assert.svh"

	// a result inside sane limits never leaves them
	`IPI_ASSERT_NOW(a_drive_in_range, clk, arst_n, out_valid_q && (cfg.out_floor <= cfg.out_ceiling), (drive_q >= cfg.out_floor) && (drive_q <= cfg.out_ceiling))
	// crossed limits force the floor and flag it
	`IPI_ASSERT_NOW(a_floor_wins, clk, arst_n, out_valid_q && (cfg.out_floor > cfg.out_ceiling), at_limit_q && (drive_q == cfg.out_floor))
	// state only moves when a sample is consumed
	`IPI_ASSERT_NEXT(a_state_hold, clk, arst_n, !advance, $stable(acc_q) && $stable(prev_err_q))
	// an empty result slot never stalls the input
	`IPI_ASSERT_NOW(a_ready_when_free, clk, arst_n, !out_valid_q, in_ready)

endmodule

/* tb/incremental_pi_controller_test.sv */
`timescale 1ns / 100ps

module incremental_pi_controller_test;
	import ipi_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int BLOCK_SAMPLES = 133;

	// one result beat as the block gives it
	typedef struct packed {
		logic [LIMIT_W-1:0] drive;
		logic               at_limit;
	} drive_beat_t;

	// predicts drive values from accepted samples and checks the result beats
	class drive_predictor;
		logic signed [DATA_W-1:0] setpoint;
		logic [GAIN_W-1:0]        prop_gain;
		logic [GAIN_W-1:0]        integ_gain;
		logic [LIMIT_W-1:0]       out_floor;
		logic [LIMIT_W-1:0]       out_ceiling;
		logic [LIMIT_W+FRAC-1:0]  accum;
		logic signed [ERR_W-1:0]  prev_error;
		drive_beat_t              expected_drives[$];
		int                       mismatches;
		int                       samples;
		int                       checked;
		int                       clamped;

		function new();
			setpoint    = SETPOINT_RST;
			prop_gain   = PROP_GAIN_RST;
			integ_gain  = INTEG_GAIN_RST;
			out_floor   = OUT_FLOOR_RST;
			out_ceiling = OUT_CEILING_RST;
			accum       = '0;
			prev_error  = '0;
		endfunction

		// only the low bits of each register are kept
		function void set_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
			case (idx)
				REG_SETPOINT:    setpoint    = value[DATA_W-1:0];
				REG_PROP_GAIN:   prop_gain   = value[GAIN_W-1:0];
				REG_INTEG_GAIN:  integ_gain  = value[GAIN_W-1:0];
				REG_OUT_FLOOR:   out_floor   = value[LIMIT_W-1:0];
				REG_OUT_CEILING: out_ceiling = value[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		// velocity-form update, round half up, ceiling first then floor
		function void take_sample(logic signed [DATA_W-1:0] meas);
			logic signed [ERR_W-1:0] err;
			logic signed [ERR_W:0]   delta;
			logic signed [47:0]      sum;
			logic signed [47:0]      inc;
			logic signed [47:0]      acc;
			logic signed [47:0]      hi;
			logic signed [47:0]      lo;
			drive_beat_t             beat;
			err   = meas - setpoint;
			delta = err - prev_error;
			sum   = $signed({1'b0, prop_gain}) * delta + $signed({1'b0, integ_gain}) * err;
			inc   = (sum + 48'sd128) >>> GAIN_FRAC;
			acc   = $signed(48'(accum)) + inc;
			hi    = $signed(48'(out_ceiling) << FRAC);
			lo    = $signed(48'(out_floor) << FRAC);
			beat.at_limit = 1'b0;
			if (acc > hi) begin
				acc = hi;
				beat.at_limit = 1'b1;
			end
			if (acc < lo) begin
				acc = lo;
				beat.at_limit = 1'b1;
			end
			accum      = acc[LIMIT_W+FRAC-1:0];
			prev_error = err;
			beat.drive = acc[LIMIT_W+FRAC-1:FRAC];
			expected_drives.push_back(beat);
			samples++;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("MISMATCH @%0t: %s", $realtime, msg);
		endtask

		task check_drive(logic [LIMIT_W-1:0] drive, logic at_limit);
			drive_beat_t want;
			if (expected_drives.size() == 0) begin
				report_mismatch($sformatf("drive %0d arrived with no sample pending", drive));
				return;
			end
			want = expected_drives.pop_front();
			checked++;
			if (want.at_limit)
				clamped++;
			if (drive !== want.drive)
				report_mismatch($sformatf("drive_value %0d, expected %0d", drive, want.drive));
			if (at_limit !== want.at_limit)
				report_mismatch($sformatf("at_limit %b, expected %b (drive %0d)",
					at_limit, want.at_limit, want.drive));
		endtask

		task check_leftovers();
			while (expected_drives.size() != 0) begin
				report_mismatch($sformatf("drive %0d never arrived",
					expected_drives[0].drive));
				void'(expected_drives.pop_front());
			end
		endtask
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]          paddr = '0;
	logic [APB_DATA_W-1:0]          pwdata = '0;
	logic [APB_DATA_W-1:0]          prdata;
	logic                           pready;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic signed [DATA_W-1:0]       measured_value = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [LIMIT_W-1:0]             drive_value;
	logic                           at_limit;

	drive_predictor model = new();
	int  valid_idle_pct = 0;
	int  ready_idle_pct = 0;
	bit  hold_armed = 1'b0;
	int  hold_count = 0;
	int  cycle_count = 0;
	int  settings_used = 0;

	incremental_pi_controller uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.measured_value(measured_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_value   (drive_value),
		.at_limit      (at_limit)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: one long hold-off when armed, else random stalls
	always @(posedge clk) begin
		if (hold_armed && hold_count < HOLD_CYCLES) begin
			out_ready <= 1'b0;
			hold_count++;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
		end
	end

	// beat monitor: results are checked before this edge's sample is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				model.check_drive(drive_value, at_limit);
			if (in_valid && in_ready)
				model.take_sample(measured_value);
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("Test completed with failures");
		$finish;
	end

	// register write: setup then access, done once pready is seen
	task automatic write_register(input logic [REG_IDX_W-1:0] idx,
			input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		model.set_register(idx, value);
	endtask

	// half the time the unused upper bits carry noise
	function automatic logic [APB_DATA_W-1:0] with_junk(input int w,
			input logic [APB_DATA_W-1:0] v);
		logic [APB_DATA_W-1:0] mask;
		mask = (32'd1 << w) - 32'd1;
		if ($urandom_range(0, 1))
			return (v & mask) | ($urandom & ~mask);
		return v & mask;
	endfunction

	task automatic apply_settings(input int sp, input int kp, input int ki,
			input int lo, input int hi);
		write_register(REG_SETPOINT, with_junk(DATA_W, sp));
		write_register(REG_PROP_GAIN, with_junk(GAIN_W, kp));
		write_register(REG_INTEG_GAIN, with_junk(GAIN_W, ki));
		write_register(REG_OUT_FLOOR, with_junk(LIMIT_W, lo));
		write_register(REG_OUT_CEILING, with_junk(LIMIT_W, hi));
		settings_used++;
	endtask

	// mostly workable loop settings, sometimes extremes or inverted limits
	task automatic choose_settings();
		int lo;
		lo = $urandom_range(0, 2000);
		case ($urandom_range(0, 9))
			5: apply_settings(SETPOINT_RST, PROP_GAIN_RST, INTEG_GAIN_RST,
				OUT_FLOOR_RST, OUT_CEILING_RST);
			6: apply_settings($urandom_range(0, 1) ? -32768 : 32767, 65535, 65535, 0, 8191);
			7: apply_settings($urandom, 0, 0, lo, $urandom_range(lo, 8191));
			8: apply_settings($urandom, $urandom_range(0, 2048), $urandom_range(0, 512),
				$urandom_range(4000, 8191), $urandom_range(0, 3999));
			9: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom);
			default: apply_settings($urandom, $urandom_range(0, 2048), $urandom_range(0, 512),
				lo, $urandom_range(lo, 8191));
		endcase
	endtask

	// offer one sample and hold it until accepted
	task automatic send_sample(input logic signed [DATA_W-1:0] v);
		while ($urandom_range(0, 99) < valid_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		measured_value <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// samples hover around the setpoint, with some full-range and extreme ones
	function automatic logic signed [DATA_W-1:0] pick_sample();
		int noise;
		noise = int'($urandom_range(0, 1023)) - 512;
		case ($urandom_range(0, 9))
			0, 1: return 16'($urandom);
			2: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
			default: return 16'(int'(model.setpoint) + noise);
		endcase
	endfunction

	// stop offering and wait until every expected result has been seen
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (model.expected_drives.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, first sample after reset lands on the floor
		valid_idle_pct = 29;
		ready_idle_pct = 87;
		send_sample(16'sd0);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(SETPOINT_RST);
		send_sample(SETPOINT_RST);
		wait_drained();

		// floor above ceiling
		apply_settings(0, PROP_GAIN_RST, INTEG_GAIN_RST, 300, 100);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		wait_drained();

		// largest gains and error swings both ways
		apply_settings(-32768, 65535, 65535, 0, 8191);
		send_sample(16'sh7fff);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		wait_drained();

		// zero ceiling
		apply_settings(32767, 65535, 65535, 0, 0);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		wait_drained();

		// zero gains hold the value exactly on the limit
		apply_settings(0, 0, 0, 10, 10);
		send_sample(16'sd100);
		send_sample(16'sd200);
		send_sample(16'sh8000);
		wait_drained();

		// random blocks under three idling patterns
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					valid_idle_pct = 29;
					ready_idle_pct = 87;
				end
				1: begin
					valid_idle_pct = 87;
					ready_idle_pct = 29;
				end
				default: begin
					valid_idle_pct = 0;
					ready_idle_pct = 0;
					hold_armed = 1'b1;
				end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				choose_settings();
				for (int n = 0; n < BLOCK_SAMPLES; n++)
					send_sample(pick_sample());
				wait_drained();
			end
		end

		repeat (8) @(posedge clk);
		model.check_leftovers();
		$display("ran %0d samples under %0d register settings, %0d results checked",
			model.samples, settings_used, model.checked);
		$display("%0d results were clamped, %0d mismatches", model.clamped, model.mismatches);
		if (model.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ipi_pkg.sv
hw/rtl/ipi_regs.sv
hw/rtl/ipi_step.sv
hw/rtl/incremental_pi_controller.sv
tb/incremental_pi_controller_test.sv
